// ===== src/yuvrgb_pkg.sv =====
package yuvrgb_pkg;

    // Default fraction bits of the normalized samples and coefficients (Q2.FRAC_BITS)
    localparam int FRAC_BITS = 16;

    localparam int SAMPLE_W = 16;
    localparam int PIXEL_W  = 8;
    localparam int CHANNELS = 3;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 24;

    // Pipeline split: normalizer stages, then matrix and output stages
    localparam int NORM_STAGES = 4;
    localparam int MAT_STAGES  = 3;
    localparam int STAGES      = NORM_STAGES + MAT_STAGES;

    // Smallest divisor is the 8-bit limited span (239), at least 2^7
    localparam int DEN_MIN_LOG2 = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_FORMAT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LIMITED = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SELECT = 2'd2;

    localparam logic [1:0] FMT_8BIT  = 2'd0;
    localparam logic [1:0] FMT_10BIT = 2'd1;
    localparam logic [1:0] FMT_16BIT = 2'd2;

    localparam logic [1:0] MAT_BT601  = 2'd0;
    localparam logic [1:0] MAT_BT709  = 2'd1;
    localparam logic [1:0] MAT_BT2020 = 2'd2;

    localparam logic [SAMPLE_W-1:0] MASK_8  = 16'h00FF;
    localparam logic [SAMPLE_W-1:0] MASK_10 = 16'h03FF;
    localparam logic [SAMPLE_W-1:0] MASK_16 = 16'hFFFF;

    localparam int SAMPLE_MAX_8  = 255;
    localparam int SAMPLE_MAX_10 = 1023;
    localparam int SAMPLE_MAX_16 = 65535;

    localparam int LUMA_OFS_8  = 16;
    localparam int LUMA_OFS_10 = 64;
    localparam int LUMA_OFS_16 = 4096;

    localparam int CHROMA_MID_8  = 128;
    localparam int CHROMA_MID_10 = 512;
    localparam int CHROMA_MID_16 = 32768;

    localparam int SPAN_8  = SAMPLE_MAX_8 - LUMA_OFS_8;
    localparam int SPAN_10 = SAMPLE_MAX_10 - LUMA_OFS_10;
    localparam int SPAN_16 = SAMPLE_MAX_16 - LUMA_OFS_16;

    // Matrix coefficients scaled by COEF_SCALE: Cr->R, Cb->G, Cr->G, Cb->B
    localparam longint COEF_SCALE = 100000;

    localparam longint K601_RV = 140200;
    localparam longint K601_GU = 34414;
    localparam longint K601_GV = 71414;
    localparam longint K601_BU = 177200;

    localparam longint K709_RV = 157480;
    localparam longint K709_GU = 18732;
    localparam longint K709_GV = 46812;
    localparam longint K709_BU = 185560;

    localparam longint K2020_RV = 147460;
    localparam longint K2020_GU = 16455;
    localparam longint K2020_GV = 57135;
    localparam longint K2020_BU = 188140;

    typedef struct packed {
        logic [1:0] sample_format;
        logic       range_limited;
        logic [1:0] matrix_select;
    } cfg_t;

endpackage

// ===== src/yuvrgb_norm.sv =====
module yuvrgb_norm #(
    parameter int FRAC_BITS = yuvrgb_pkg::FRAC_BITS
) (
    input  logic                                    aclk,
    input  logic [yuvrgb_pkg::NORM_STAGES-1:0]      stage_en,
    input  yuvrgb_pkg::cfg_t                        cfg,
    input  logic [yuvrgb_pkg::SAMPLE_W-1:0]         sample_in [yuvrgb_pkg::CHANNELS],
    output logic signed [FRAC_BITS+1:0]             norm_out  [yuvrgb_pkg::CHANNELS]
);

    localparam int MW  = yuvrgb_pkg::SAMPLE_W;
    localparam int NCH = yuvrgb_pkg::CHANNELS;
    localparam int K   = MW + 1;
    localparam int RW  = FRAC_BITS + K - yuvrgb_pkg::DEN_MIN_LOG2;
    localparam int QW  = FRAC_BITS + 1;
    localparam int VW  = FRAC_BITS + 2;
    localparam int TW  = MW + FRAC_BITS + 1;
    localparam int RMW = MW + 1;
    localparam int R2W = MW + 2;
    localparam int PW  = MW + RW;

    localparam logic [63:0] SCALE = 64'd1 << (FRAC_BITS + K);

    localparam logic [RW-1:0] REC_FULL_8   = RW'(SCALE / 64'(yuvrgb_pkg::SAMPLE_MAX_8));
    localparam logic [RW-1:0] REC_FULL_10  = RW'(SCALE / 64'(yuvrgb_pkg::SAMPLE_MAX_10));
    localparam logic [RW-1:0] REC_FULL_16  = RW'(SCALE / 64'(yuvrgb_pkg::SAMPLE_MAX_16));
    localparam logic [RW-1:0] REC_LIM_8    = RW'(SCALE / 64'(yuvrgb_pkg::SPAN_8));
    localparam logic [RW-1:0] REC_LIM_10   = RW'(SCALE / 64'(yuvrgb_pkg::SPAN_10));
    localparam logic [RW-1:0] REC_LIM_16   = RW'(SCALE / 64'(yuvrgb_pkg::SPAN_16));

    localparam logic signed [VW-1:0] HALF_UNIT = VW'(64'd1 << (FRAC_BITS - 1));

    // divisor selection (the user must keep the configuration static while items are in flight; not enforced here)
    logic [MW-1:0]  mask_sel;
    logic [MW-1:0]  luma_ofs;
    logic [MW-1:0]  chroma_ofs;
    logic [MW-1:0]  den;
    logic [R2W-1:0] den3;
    logic [RW-1:0]  rec;

    logic [MW-1:0]  mag0_reg  [NCH];
    logic [MW-1:0]  mag0_next [NCH];
    logic           neg0_reg  [NCH];
    logic           neg0_next [NCH];

    logic [QW-1:0]  qe1_reg   [NCH];
    logic [QW-1:0]  qe1_next  [NCH];
    logic [MW-1:0]  mag1_reg  [NCH];
    logic           neg1_reg  [NCH];

    logic [QW-1:0]  qe2_reg   [NCH];
    logic [RMW-1:0] rem2_reg  [NCH];
    logic [RMW-1:0] rem2_next [NCH];
    logic           neg2_reg  [NCH];

    logic signed [VW-1:0] norm_reg  [NCH];
    logic signed [VW-1:0] norm_next [NCH];

    always_comb begin
        case (cfg.sample_format)
            yuvrgb_pkg::FMT_8BIT: begin
                mask_sel   = yuvrgb_pkg::MASK_8;
                luma_ofs   = MW'(yuvrgb_pkg::LUMA_OFS_8);
                chroma_ofs = MW'(yuvrgb_pkg::CHROMA_MID_8);
                den        = cfg.range_limited ? MW'(yuvrgb_pkg::SPAN_8)
                                               : MW'(yuvrgb_pkg::SAMPLE_MAX_8);
                rec        = cfg.range_limited ? REC_LIM_8 : REC_FULL_8;
            end
            yuvrgb_pkg::FMT_10BIT: begin
                mask_sel   = yuvrgb_pkg::MASK_10;
                luma_ofs   = MW'(yuvrgb_pkg::LUMA_OFS_10);
                chroma_ofs = MW'(yuvrgb_pkg::CHROMA_MID_10);
                den        = cfg.range_limited ? MW'(yuvrgb_pkg::SPAN_10)
                                               : MW'(yuvrgb_pkg::SAMPLE_MAX_10);
                rec        = cfg.range_limited ? REC_LIM_10 : REC_FULL_10;
            end
            default: begin
                mask_sel   = yuvrgb_pkg::MASK_16;
                luma_ofs   = MW'(yuvrgb_pkg::LUMA_OFS_16);
                chroma_ofs = MW'(yuvrgb_pkg::CHROMA_MID_16);
                den        = cfg.range_limited ? MW'(yuvrgb_pkg::SPAN_16)
                                               : MW'(yuvrgb_pkg::SAMPLE_MAX_16);
                rec        = cfg.range_limited ? REC_LIM_16 : REC_FULL_16;
            end
        endcase
        den3 = {2'b00, den} + {1'b0, den, 1'b0};
    end

    // Stage 0: mask, remove offset, split into sign and magnitude
    always_comb begin
        logic [MW-1:0] masked;
        logic [MW-1:0] ofs;
        logic [MW:0]   diff;
        logic [MW:0]   diff_neg;
        for (int i = 0; i < NCH; i++) begin
            masked = sample_in[i] & mask_sel;
            if (!cfg.range_limited) begin
                ofs = '0;
            end else if (i == 0) begin
                ofs = luma_ofs;
            end else begin
                ofs = chroma_ofs;
            end
            diff         = {1'b0, masked} - {1'b0, ofs};
            diff_neg     = -diff;
            neg0_next[i] = diff[MW];
            mag0_next[i] = diff[MW] ? diff_neg[MW-1:0] : diff[MW-1:0];
        end
    end

    // Stage 1: quotient estimate by reciprocal; at most one below the floor
    always_comb begin
        logic [PW-1:0] prod;
        for (int i = 0; i < NCH; i++) begin
            prod        = mag0_reg[i] * rec;
            qe1_next[i] = prod[K +: QW];
        end
    end

    // Stage 2: remainder of the estimate, lies in [0, 2*den)
    always_comb begin
        logic [TW-1:0] pd;
        logic [TW-1:0] diff;
        for (int i = 0; i < NCH; i++) begin
            pd           = qe1_reg[i] * den;
            diff         = {1'b0, mag1_reg[i], FRAC_BITS'(0)} - pd;
            rem2_next[i] = diff[RMW-1:0];
        end
    end

    // Stage 3: correct and round half up on the magnitude, restore sign; full-range chroma less one half
    always_comb begin
        logic [R2W-1:0]       rem_x2;
        logic [1:0]           inc;
        logic [QW-1:0]        q;
        logic signed [VW-1:0] qs;
        logic signed [VW-1:0] v;
        for (int i = 0; i < NCH; i++) begin
            rem_x2 = {rem2_reg[i], 1'b0};
            inc    = {1'b0, rem_x2 >= {2'b00, den}} + {1'b0, rem_x2 >= den3};
            q      = qe2_reg[i] + QW'(inc);
            qs     = $signed({1'b0, q});
            v      = neg2_reg[i] ? -qs : qs;
            if (!cfg.range_limited && i != 0) begin
                v = v - HALF_UNIT;
            end
            norm_next[i] = v;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < NCH; i++) begin
            if (stage_en[0]) begin
                mag0_reg[i] <= mag0_next[i];
                neg0_reg[i] <= neg0_next[i];
            end
            if (stage_en[1]) begin
                qe1_reg[i]  <= qe1_next[i];
                mag1_reg[i] <= mag0_reg[i];
                neg1_reg[i] <= neg0_reg[i];
            end
            if (stage_en[2]) begin
                qe2_reg[i]  <= qe1_reg[i];
                rem2_reg[i] <= rem2_next[i];
                neg2_reg[i] <= neg1_reg[i];
            end
            if (stage_en[3]) begin
                norm_reg[i] <= norm_next[i];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            norm_out[i] = norm_reg[i];
        end
    end

endmodule

// ===== src/yuvrgb_matrix.sv =====
module yuvrgb_matrix #(
    parameter int FRAC_BITS = yuvrgb_pkg::FRAC_BITS
) (
    input  logic                                aclk,
    input  logic [yuvrgb_pkg::MAT_STAGES-1:0]   stage_en,
    input  yuvrgb_pkg::cfg_t                    cfg,
    input  logic signed [FRAC_BITS+1:0]         norm_in [yuvrgb_pkg::CHANNELS],
    output logic [yuvrgb_pkg::PIXEL_W-1:0]      red,
    output logic [yuvrgb_pkg::PIXEL_W-1:0]      green,
    output logic [yuvrgb_pkg::PIXEL_W-1:0]      blue
);

    localparam int NCH = yuvrgb_pkg::CHANNELS;
    localparam int PXW = yuvrgb_pkg::PIXEL_W;
    localparam int VW  = FRAC_BITS + 2;
    localparam int CW  = FRAC_BITS + 1;
    localparam int PW  = 2 * FRAC_BITS + 4;
    localparam int CLW = 2 * FRAC_BITS + 1;
    localparam int XW  = CLW + PXW;

    localparam longint UNIT = longint'(1) << FRAC_BITS;
    localparam longint HALF = yuvrgb_pkg::COEF_SCALE / 2;
    localparam longint SC   = yuvrgb_pkg::COEF_SCALE;

    localparam logic [CW-1:0] C601_RV  = CW'((yuvrgb_pkg::K601_RV * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C601_GU  = CW'((yuvrgb_pkg::K601_GU * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C601_GV  = CW'((yuvrgb_pkg::K601_GV * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C601_BU  = CW'((yuvrgb_pkg::K601_BU * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C709_RV  = CW'((yuvrgb_pkg::K709_RV * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C709_GU  = CW'((yuvrgb_pkg::K709_GU * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C709_GV  = CW'((yuvrgb_pkg::K709_GV * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C709_BU  = CW'((yuvrgb_pkg::K709_BU * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C2020_RV = CW'((yuvrgb_pkg::K2020_RV * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C2020_GU = CW'((yuvrgb_pkg::K2020_GU * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C2020_GV = CW'((yuvrgb_pkg::K2020_GV * UNIT + HALF) / SC);
    localparam logic [CW-1:0] C2020_BU = CW'((yuvrgb_pkg::K2020_BU * UNIT + HALF) / SC);

    localparam logic signed [PW-1:0] ONE_SUM  = PW'(64'd1 << (2 * FRAC_BITS));
    localparam logic [XW-1:0]        HALF_OUT = XW'(64'd1 << (2 * FRAC_BITS - 1));

    logic [CW-1:0] krv;
    logic [CW-1:0] kgu;
    logic [CW-1:0] kgv;
    logic [CW-1:0] kbu;

    logic signed [PW-1:0] prv_reg;
    logic signed [PW-1:0] prv_next;
    logic signed [PW-1:0] pgu_reg;
    logic signed [PW-1:0] pgu_next;
    logic signed [PW-1:0] pgv_reg;
    logic signed [PW-1:0] pgv_next;
    logic signed [PW-1:0] pbu_reg;
    logic signed [PW-1:0] pbu_next;
    logic signed [VW-1:0] luma_reg;

    logic [CLW-1:0] clamp_reg  [NCH];
    logic [CLW-1:0] clamp_next [NCH];

    logic [PXW-1:0] pix_reg  [NCH];
    logic [PXW-1:0] pix_next [NCH];

    always_comb begin
        case (cfg.matrix_select)
            yuvrgb_pkg::MAT_BT709: begin
                krv = C709_RV;
                kgu = C709_GU;
                kgv = C709_GV;
                kbu = C709_BU;
            end
            yuvrgb_pkg::MAT_BT2020: begin
                krv = C2020_RV;
                kgu = C2020_GU;
                kgv = C2020_GV;
                kbu = C2020_BU;
            end
            default: begin
                krv = C601_RV;
                kgu = C601_GU;
                kgv = C601_GV;
                kbu = C601_BU;
            end
        endcase
    end

    // Stage 0: the four chroma products
    always_comb begin
        prv_next = $signed({1'b0, krv}) * norm_in[2];
        pgu_next = $signed({1'b0, kgu}) * norm_in[1];
        pgv_next = $signed({1'b0, kgv}) * norm_in[1 + 1];
        pbu_next = $signed({1'b0, kbu}) * norm_in[1];
    end

    // Stage 1: channel sums with 2*FRAC_BITS fraction bits, clamp to [0,1]
    always_comb begin
        logic signed [PW-1:0] luma_x;
        logic signed [PW-1:0] sum [NCH];
        luma_x = PW'(luma_reg) <<< FRAC_BITS;
        sum[0] = luma_x + prv_reg;
        sum[1] = luma_x - pgu_reg - pgv_reg;
        sum[2] = luma_x + pbu_reg;
        for (int i = 0; i < NCH; i++) begin
            if (sum[i] < 0) begin
                clamp_next[i] = '0;
            end else if (sum[i] > ONE_SUM) begin
                clamp_next[i] = ONE_SUM[CLW-1:0];
            end else begin
                clamp_next[i] = sum[i][CLW-1:0];
            end
        end
    end

    // Stage 2: scale by 255 as shift and subtract, add one half, truncate
    always_comb begin
        logic [XW-1:0] scaled;
        for (int i = 0; i < NCH; i++) begin
            scaled      = {clamp_reg[i], PXW'(0)} - XW'(clamp_reg[i]) + HALF_OUT;
            pix_next[i] = scaled[2 * FRAC_BITS +: PXW];
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            prv_reg  <= prv_next;
            pgu_reg  <= pgu_next;
            pgv_reg  <= pgv_next;
            pbu_reg  <= pbu_next;
            luma_reg <= norm_in[0];
        end
        for (int i = 0; i < NCH; i++) begin
            if (stage_en[1]) begin
                clamp_reg[i] <= clamp_next[i];
            end
            if (stage_en[2]) begin
                pix_reg[i] <= pix_next[i];
            end
        end
    end

    assign red   = pix_reg[0];
    assign green = pix_reg[1];
    assign blue  = pix_reg[2];

endmodule

// ===== src/yuv_to_rgb_pixel_converter_core.sv =====
// YCbCr to RGB pixel converter.
// Input stream (s_*): one pixel per request, tdata = {cr, cb, luma}, 16 bits each.
// Narrow sample formats use only the low bits of each sample.
// Output stream (m_*): one RGB pixel per accepted input, tdata = {blue, green, red}.
// Configuration: cfg_wr_en/cfg_wr_index/cfg_wr_data write sample_format (0),
// range_limited (1) and matrix_select (2); write only while no pixel is in flight.
// Datapath: a seven-stage pipeline from an accepted input request to m_tvalid
// (4 normalizer stages: offset, reciprocal multiply, remainder, rounding;
// 3 matrix stages: products, sums and clamp, 8-bit scaling).
// Throughput: one pixel per clock while m_tready stays high.
// Reset (aresetn low, synchronous) empties the pipeline and sets the configuration to 0.
// When the receiver stalls, the result holds on m_tdata; earlier stages keep
// accepting until every stage is full, then s_tready drops. Nothing is lost or
// repeated.
module yuv_to_rgb_pixel_converter_core #(
    parameter int FRAC_BITS = yuvrgb_pkg::FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [15:0] luma_sample, [31:16] cb_sample, [47:32] cr_sample
    input  logic [yuvrgb_pkg::IN_DATA_W-1:0]    s_tdata,

    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] red, [15:8] green, [23:16] blue
    output logic [yuvrgb_pkg::OUT_DATA_W-1:0]   m_tdata,

    input  logic                                cfg_wr_en,
    input  logic [yuvrgb_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [yuvrgb_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    localparam int NS  = yuvrgb_pkg::STAGES;
    localparam int NN  = yuvrgb_pkg::NORM_STAGES;
    localparam int SW  = yuvrgb_pkg::SAMPLE_W;
    localparam int NCH = yuvrgb_pkg::CHANNELS;

    yuvrgb_pkg::cfg_t cfg_reg;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] stage_en;

    logic [SW-1:0]              sample_in [NCH];
    logic signed [FRAC_BITS+1:0] norm      [NCH];

    logic [yuvrgb_pkg::PIXEL_W-1:0] red;
    logic [yuvrgb_pkg::PIXEL_W-1:0] green;
    logic [yuvrgb_pkg::PIXEL_W-1:0] blue;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                yuvrgb_pkg::CFG_SAMPLE_FORMAT: cfg_reg.sample_format <= cfg_wr_data;
                yuvrgb_pkg::CFG_RANGE_LIMITED: cfg_reg.range_limited <= cfg_wr_data[0];
                yuvrgb_pkg::CFG_MATRIX_SELECT: cfg_reg.matrix_select <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // A stage advances when it is empty or the stage after it advances
    always_comb begin
        stage_en[NS-1] = !valid_reg[NS-1] || m_tready;
        for (int i = NS - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i + 1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (stage_en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < NS; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_reg[i - 1];
                end
            end
        end
    end

    // hold off requests while in reset
    assign s_tready = aresetn && stage_en[0];
    assign m_tvalid = valid_reg[NS-1];

    always_comb begin
        for (int i = 0; i < NCH; i++) begin
            sample_in[i] = s_tdata[i * SW +: SW];
        end
    end

    yuvrgb_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .aclk      (aclk),
        .stage_en  (stage_en[NN-1:0]),
        .cfg       (cfg_reg),
        .sample_in (sample_in),
        .norm_out  (norm)
    );

    yuvrgb_matrix #(
        .FRAC_BITS (FRAC_BITS)
    ) u_matrix (
        .aclk     (aclk),
        .stage_en (stage_en[NS-1:NN]),
        .cfg      (cfg_reg),
        .norm_in  (norm),
        .red      (red),
        .green    (green),
        .blue     (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

// ===== verif/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import yuvrgb_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 22;
    localparam int PHASE_ITEMS  = 48;
    localparam int DRAIN_CYCLES = STAGES + 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_MAX   = 10;

    // index with no register behind it; writes to it must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam logic [1:0] FMT_ALIAS = 2'd3;
    localparam logic [1:0] MAT_ALIAS = 2'd3;

    typedef struct packed {
        logic [SAMPLE_W-1:0] cr;
        logic [SAMPLE_W-1:0] cb;
        logic [SAMPLE_W-1:0] luma;
    } yuv_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] blue;
        logic [PIXEL_W-1:0] green;
        logic [PIXEL_W-1:0] red;
    } rgb_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic                   cfg_wr_en;
    logic [CFG_IDX_W-1:0]   cfg_wr_index;
    logic [CFG_DATA_W-1:0]  cfg_wr_data;

    // register shadow, updated on the edge that writes the block
    logic [1:0] fmt_reg;
    logic       lim_reg;
    logic [1:0] mat_reg;

    yuv_t   yuv_pending[$];
    rgb_t   rgb_expected[$];
    bit     s_taken;
    bit     no_idle;
    int     cycle_count;
    int     pixels_in;
    int     pixels_out;
    int     mismatch_count;
    int     phase_count;

    yuv_to_rgb_pixel_converter_core u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    function automatic longint round_div(longint num, longint den);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag + den) / (2 * den);
        return (num < 0) ? -q : q;
    endfunction

    function automatic longint coef_q(longint k);
        return (k * (longint'(1) << FRAC_BITS) + COEF_SCALE / 2) / COEF_SCALE;
    endfunction

    // clamp to [0,1] and round to 8 bits
    function automatic logic [PIXEL_W-1:0] scale_channel(longint sum);
        longint one;
        longint s;
        one = longint'(1) << (2 * FRAC_BITS);
        s = sum;
        if (s < 0) s = 0;
        if (s > one) s = one;
        s = (s * 255 + (longint'(1) << (2 * FRAC_BITS - 1))) >>> (2 * FRAC_BITS);
        return s[PIXEL_W-1:0];
    endfunction

    function automatic rgb_t convert_pixel(yuv_t px);
        logic [SAMPLE_W-1:0] mask;
        longint unit, ymax, ymin, mid, span;
        longint y, u, v, yn, un, vn;
        longint krv, kgu, kgv, kbu;
        rgb_t res;
        unit = longint'(1) << FRAC_BITS;
        case (fmt_reg)
            FMT_8BIT: begin
                mask = MASK_8;  ymax = SAMPLE_MAX_8;  ymin = LUMA_OFS_8;  mid = CHROMA_MID_8;
            end
            FMT_10BIT: begin
                mask = MASK_10; ymax = SAMPLE_MAX_10; ymin = LUMA_OFS_10; mid = CHROMA_MID_10;
            end
            default: begin
                mask = MASK_16; ymax = SAMPLE_MAX_16; ymin = LUMA_OFS_16; mid = CHROMA_MID_16;
            end
        endcase
        y = longint'(px.luma & mask);
        u = longint'(px.cb & mask);
        v = longint'(px.cr & mask);
        if (lim_reg) begin
            // chroma is scaled by the luma span as well
            span = ymax - ymin;
            yn = round_div((y - ymin) * unit, span);
            un = round_div((u - mid) * unit, span);
            vn = round_div((v - mid) * unit, span);
        end else begin
            yn = round_div(y * unit, ymax);
            un = round_div(u * unit, ymax) - unit / 2;
            vn = round_div(v * unit, ymax) - unit / 2;
        end
        case (mat_reg)
            MAT_BT709: begin
                krv = coef_q(K709_RV); kgu = coef_q(K709_GU);
                kgv = coef_q(K709_GV); kbu = coef_q(K709_BU);
            end
            MAT_BT2020: begin
                krv = coef_q(K2020_RV); kgu = coef_q(K2020_GU);
                kgv = coef_q(K2020_GV); kbu = coef_q(K2020_BU);
            end
            default: begin
                krv = coef_q(K601_RV); kgu = coef_q(K601_GU);
                kgv = coef_q(K601_GV); kbu = coef_q(K601_BU);
            end
        endcase
        res.red   = scale_channel(yn * unit + krv * vn);
        res.green = scale_channel(yn * unit - kgu * un - kgv * vn);
        res.blue  = scale_channel(yn * unit + kbu * un);
        return res;
    endfunction

    // bias samples toward the edges and the offsets of the format
    function automatic logic [SAMPLE_W-1:0] random_sample(logic [1:0] fmt, bit is_luma);
        int maxv;
        int ctr;
        int pick;
        case (fmt)
            FMT_8BIT: begin
                maxv = SAMPLE_MAX_8;  ctr = is_luma ? LUMA_OFS_8 : CHROMA_MID_8;
            end
            FMT_10BIT: begin
                maxv = SAMPLE_MAX_10; ctr = is_luma ? LUMA_OFS_10 : CHROMA_MID_10;
            end
            default: begin
                maxv = SAMPLE_MAX_16; ctr = is_luma ? LUMA_OFS_16 : CHROMA_MID_16;
            end
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0: return '0;
            1: return SAMPLE_W'(maxv);
            2: return SAMPLE_W'($urandom_range(0, 65535));
            3: return SAMPLE_W'(ctr + $urandom_range(0, 8) - 4);
            4: return SAMPLE_W'(maxv - $urandom_range(0, 24));
            default: return SAMPLE_W'($urandom_range(0, maxv));
        endcase
    endfunction

    function automatic yuv_t make_pixel(int luma, int cb, int cr);
        yuv_t px;
        px.luma = SAMPLE_W'(luma);
        px.cb   = SAMPLE_W'(cb);
        px.cr   = SAMPLE_W'(cr);
        return px;
    endfunction

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= data;
        @(negedge aclk);
        cfg_wr_en    <= 1'b0;
    endtask

    // wait until every request is out and every pixel is back, then let the pipe settle
    task automatic drain_pipe();
        while (yuv_pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (rgb_expected.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        aclk = 1'b0;
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // request driver
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (yuv_pending.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                s_tdata  <= yuv_pending.pop_front();
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(negedge aclk) begin
        m_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // monitor: predict on accepted requests, check on accepted results
    always @(posedge aclk) begin
        rgb_t got;
        rgb_t want;
        cycle_count++;
        s_taken = 1'b0;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                rgb_expected.push_back(convert_pixel(yuv_t'(s_tdata)));
                s_taken = 1'b1;
                pixels_in++;
            end
            if (m_tvalid && m_tready) begin
                got = rgb_t'(m_tdata);
                pixels_out++;
                if (rgb_expected.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("unexpected pixel r=%0d g=%0d b=%0d at cycle %0d",
                                 got.red, got.green, got.blue, cycle_count);
                end else begin
                    want = rgb_expected.pop_front();
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("pixel %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                     pixels_out - 1, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end
            if (cfg_wr_en) begin
                case (cfg_wr_index)
                    CFG_SAMPLE_FORMAT: fmt_reg = cfg_wr_data[1:0];
                    CFG_RANGE_LIMITED: lim_reg = cfg_wr_data[0];
                    CFG_MATRIX_SELECT: mat_reg = cfg_wr_data[1:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge aclk) begin
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d pixels outstanding",
                     cycle_count, rgb_expected.size());
            $display("[yuv_to_rgb_pixel_converter_core] ERROR");
            $finish;
        end
    end

    initial begin
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_wr_index   = '0;
        cfg_wr_data    = '0;
        fmt_reg        = FMT_8BIT;
        lim_reg        = 1'b0;
        mat_reg        = MAT_BT601;
        s_taken        = 1'b0;
        no_idle        = 1'b0;
        cycle_count    = 0;
        pixels_in      = 0;
        pixels_out     = 0;
        mismatch_count = 0;
        phase_count    = 0;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset config: 8-bit full range BT.601; extremes, masked upper bits, clamping
        yuv_pending.push_back(make_pixel(0, 0, 0));
        yuv_pending.push_back(make_pixel(255, 255, 255));
        yuv_pending.push_back(make_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF));
        yuv_pending.push_back(make_pixel(16'hFF00, 16'h1280, 16'hAB80));
        yuv_pending.push_back(make_pixel(0, 255, 255));
        yuv_pending.push_back(make_pixel(255, 0, 0));
        yuv_pending.push_back(make_pixel(128, 128, 128));
        yuv_pending.push_back(make_pixel(0, 0, 255));
        yuv_pending.push_back(make_pixel(255, 255, 0));
        yuv_pending.push_back(make_pixel(16'h5555, 16'hAAAA, 16'h5555));
        drain_pipe();

        // studio range: offsets, nominal peaks and values outside the nominal band
        write_reg(CFG_RANGE_LIMITED, 2'd1);
        yuv_pending.push_back(make_pixel(16, 128, 128));
        yuv_pending.push_back(make_pixel(235, 240, 240));
        yuv_pending.push_back(make_pixel(0, 0, 0));
        yuv_pending.push_back(make_pixel(255, 255, 255));
        yuv_pending.push_back(make_pixel(0, 0, 255));
        yuv_pending.push_back(make_pixel(255, 255, 0));
        yuv_pending.push_back(make_pixel(16'hAAAA, 16'h5555, 16'hAAAA));
        drain_pipe();

        // alias codes: format 3 acts as 16-bit, matrix 3 as BT.601
        write_reg(CFG_SAMPLE_FORMAT, FMT_ALIAS);
        write_reg(CFG_MATRIX_SELECT, MAT_ALIAS);
        yuv_pending.push_back(make_pixel(65535, 0, 65535));
        yuv_pending.push_back(make_pixel(4096, 32768, 32768));
        yuv_pending.push_back(make_pixel(0, 65535, 0));
        drain_pipe();

        for (int f = 0; f < 4; f++) begin
            for (int l = 0; l < 2; l++) begin
                for (int m = 0; m < 4; m++) begin
                    phase_count++;
                    // run a block of phases with both sides always ready
                    no_idle = (phase_count >= 12 && phase_count < 16);
                    write_reg(CFG_SAMPLE_FORMAT, 2'(f));
                    // upper data bit of the one-bit register must be ignored
                    write_reg(CFG_RANGE_LIMITED, {1'($urandom_range(0, 1)), 1'(l)});
                    write_reg(CFG_MATRIX_SELECT, 2'(m));
                    if ($urandom_range(0, 3) == 0)
                        write_reg(CFG_UNUSED, 2'($urandom_range(0, 3)));
                    for (int i = 0; i < PHASE_ITEMS; i++)
                        yuv_pending.push_back(make_pixel(random_sample(2'(f), 1'b1),
                                                         random_sample(2'(f), 1'b0),
                                                         random_sample(2'(f), 1'b0)));
                    drain_pipe();
                end
            end
        end

        $display("converted %0d pixels (%0d returned) across %0d register settings",
                 pixels_in, pixels_out, phase_count + 3);
        $display("%0d mismatches, %0d cycles", mismatch_count, cycle_count);
        if (mismatch_count == 0 && rgb_expected.size() == 0) begin
            $display("[yuv_to_rgb_pixel_converter_core] OK");
        end else begin
            $display("[yuv_to_rgb_pixel_converter_core] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
src/yuvrgb_pkg.sv
src/yuvrgb_norm.sv
src/yuvrgb_matrix.sv
src/yuv_to_rgb_pixel_converter_core.sv
verif/testbench.sv
